@@ hdl/stk500_bootloader_engine_unit_defines.svh @@
// Assertion macros used by the engine's top-level RTL file.
`ifndef STK500_BOOTLOADER_ENGINE_UNIT_DEFINES_SVH
`define STK500_BOOTLOADER_ENGINE_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as its trigger.
`define STK_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Condition must hold in the cycle after its trigger.
`define STK_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hdl/stk_pkg.sv @@
// Shared types and constants of the STK500 bootloader engine.
`timescale 1ns / 1ps

package stk_pkg;

	// Program store size in bytes; a power of two from 256 to 262144.
	localparam int STORE_BYTES = 65536;
	localparam int STORE_AW    = $clog2(STORE_BYTES);

	// Command queue between parser and executor.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam logic [Q_AW:0] Q_CNT_FULL = (Q_AW + 1)'(Q_DEPTH);

	// Protocol bytes.
	localparam logic [7:0] B_INSYNC      = 8'h14;
	localparam logic [7:0] B_OK          = 8'h10;
	localparam logic [7:0] B_EOP         = 8'h20;
	localparam logic [7:0] PARAM_UNKNOWN = 8'h03;
	localparam logic [7:0] UNIV_REPLY    = 8'h00;

	// Command codes.
	localparam logic [7:0] CMD_GET_PARAM  = 8'h41;
	localparam logic [7:0] CMD_SET_DEV    = 8'h42;
	localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
	localparam logic [7:0] CMD_LEAVE      = 8'h51;
	localparam logic [7:0] CMD_LOAD_ADDR  = 8'h55;
	localparam logic [7:0] CMD_UNIVERSAL  = 8'h56;
	localparam logic [7:0] CMD_PROG_PAGE  = 8'h64;
	localparam logic [7:0] CMD_READ_PAGE  = 8'h74;
	localparam logic [7:0] CMD_READ_SIG   = 8'h75;

	// Parameter selects.
	localparam logic [7:0] PARAM_MAJOR = 8'h81;
	localparam logic [7:0] PARAM_MINOR = 8'h82;

	// Operand bytes skipped by the device setup and universal commands.
	localparam logic [15:0] SKIP_SET_DEV     = 16'd20;
	localparam logic [15:0] SKIP_SET_DEV_EXT = 16'd5;
	localparam logic [15:0] SKIP_UNIVERSAL   = 16'd4;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_VER_MAJOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VER_MINOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_THIRD = 3'd4;

	localparam logic [7:0] RST_VER_MAJOR  = 8'd8;
	localparam logic [7:0] RST_VER_MINOR  = 8'd0;
	localparam logic [7:0] RST_SIG_FIRST  = 8'd30;
	localparam logic [7:0] RST_SIG_SECOND = 8'd149;
	localparam logic [7:0] RST_SIG_THIRD  = 8'd15;

	typedef struct packed {
		logic [7:0] version_major;
		logic [7:0] version_minor;
		logic [7:0] signature_first;
		logic [7:0] signature_second;
		logic [7:0] signature_third;
	} cfg_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PARAM,
		PH_SKIP,
		PH_ADDR_LO,
		PH_ADDR_HI,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DEST,
		PH_DATA,
		PH_EOP,
		PH_PENDING,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_REPLY
	} op_kind_t;

	// Reply shapes: SYNC = INSYNC only, SHORT = INSYNC OK,
	// DATA = INSYNC byte OK, SIG = INSYNC three signature bytes OK.
	typedef enum logic [1:0] {
		RPL_SYNC,
		RPL_SHORT,
		RPL_DATA,
		RPL_SIG
	} rpl_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		rpl_kind_t           rpl;
		logic                last_rd;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
		logic                serr;
		logic                pending;
		logic                finished;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef logic [2:0] seq_idx_t;

endpackage

@@ hdl/stk_cmd_if.sv @@
// Input channel: received bytes and transmit slots.
`timescale 1ns / 1ps

interface stk_cmd_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

@@ hdl/stk_rsp_if.sv @@
// Output channel: bytes to send to the host.
`timescale 1ns / 1ps

interface stk_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	logic       sync_error;
	logic       page_pending;
	logic       finished;

	modport source (output valid, output tx_byte, output last, output sync_error,
		output page_pending, output finished, input ready);
	modport sink (input valid, input tx_byte, input last, input sync_error,
		input page_pending, input finished, output ready);
endinterface

@@ hdl/stk_front.sv @@
// Command parser: one item per cycle while cmd.ready; queues store and reply ops.
`timescale 1ns / 1ps

module stk_front (
	input  logic              clk,
	input  logic              arst_n,
	stk_cmd_if.sink           cmd,
	input  stk_pkg::cfg_t     cfg,
	input  logic              clr_busy,
	input  stk_pkg::q_status_t q_st,
	output logic              push,
	output stk_pkg::op_t      push_op
);
	import stk_pkg::*;

	phase_t              phase_q, phase_d;
	logic [7:0]          cmd_q, cmd_d;
	logic [15:0]         bc_q, bc_d;
	logic [15:0]         addr_q, addr_d;
	logic [15:0]         plen_q, plen_d;
	logic [7:0]          psel_q, psel_d;
	logic                done_q, done_d;
	logic                take;
	logic [15:0]         bc_inc;
	logic [15:0]         bc_dec;
	logic [17:0]         idx_sum;

	assign cmd.ready = !clr_busy && !q_st.full;
	assign take      = cmd.valid && cmd.ready;
	assign bc_inc    = bc_q + 16'd1;
	assign bc_dec    = (bc_q != 16'd0) ? bc_q - 16'd1 : bc_q;
	// byte index = 2 * word address + offset, wrapped to the store size
	assign idx_sum   = {1'b0, addr_q, 1'b0} + {2'b00, bc_q};

	// next state
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		bc_d    = bc_q;
		addr_d  = addr_q;
		plen_d  = plen_q;
		psel_d  = psel_q;
		done_d  = done_q;
		if (take && !done_q) begin
			if (cmd.action) begin
				if (phase_q == PH_PENDING) begin
					bc_d = bc_inc;
					if (bc_inc >= plen_q)
						phase_d = PH_IDLE;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						cmd_d = cmd.rx_byte;
						unique case (cmd.rx_byte)
							CMD_GET_PARAM: phase_d = PH_PARAM;
							CMD_SET_DEV: begin
								bc_d    = SKIP_SET_DEV;
								phase_d = PH_SKIP;
							end
							CMD_SET_DEV_EXT: begin
								bc_d    = SKIP_SET_DEV_EXT;
								phase_d = PH_SKIP;
							end
							CMD_UNIVERSAL: begin
								bc_d    = SKIP_UNIVERSAL;
								phase_d = PH_SKIP;
							end
							CMD_LOAD_ADDR: phase_d = PH_ADDR_LO;
							CMD_PROG_PAGE, CMD_READ_PAGE: phase_d = PH_LEN_HI;
							default: phase_d = PH_EOP;
						endcase
					end
					PH_PARAM: begin
						psel_d  = cmd.rx_byte;
						phase_d = PH_EOP;
					end
					PH_SKIP: begin
						bc_d = bc_dec;
						if (bc_dec == 16'd0)
							phase_d = PH_EOP;
					end
					PH_ADDR_LO: begin
						addr_d  = {addr_q[15:8], cmd.rx_byte};
						phase_d = PH_ADDR_HI;
					end
					PH_ADDR_HI: begin
						addr_d  = {cmd.rx_byte, addr_q[7:0]};
						phase_d = PH_EOP;
					end
					PH_LEN_HI: begin
						plen_d  = {cmd.rx_byte, 8'h00};
						phase_d = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						plen_d  = {plen_q[15:8], cmd.rx_byte};
						phase_d = PH_DEST;
					end
					PH_DEST: begin
						bc_d = 16'd0;
						if (cmd_q == CMD_PROG_PAGE && plen_q != 16'd0)
							phase_d = PH_DATA;
						else
							phase_d = PH_EOP;
					end
					PH_DATA: begin
						bc_d = bc_inc;
						if (bc_inc >= plen_q)
							phase_d = PH_EOP;
					end
					PH_EOP: begin
						phase_d = PH_IDLE;
						if (cmd_q == CMD_LEAVE) begin
							done_d  = 1'b1;
							phase_d = PH_DONE;
						end else if (cmd_q == CMD_READ_PAGE) begin
							bc_d = 16'd0;
							if (plen_q != 16'd0)
								phase_d = PH_PENDING;
						end
					end
					PH_PENDING, PH_DONE: begin
						phase_d = phase_q;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// queued operation
	always_comb begin
		push             = 1'b0;
		push_op          = '0;
		push_op.kind     = OP_REPLY;
		push_op.rpl      = RPL_SHORT;
		push_op.last_rd  = bc_inc >= plen_q;
		push_op.addr     = idx_sum[STORE_AW-1:0];
		push_op.data     = cmd.rx_byte;
		push_op.serr     = 1'b0;
		push_op.pending  = phase_d == PH_PENDING;
		push_op.finished = done_d;
		if (take && !done_q) begin
			if (cmd.action) begin
				if (phase_q == PH_PENDING) begin
					push         = 1'b1;
					push_op.kind = OP_READ;
				end
			end else if (phase_q == PH_DATA) begin
				push         = 1'b1;
				push_op.kind = OP_WRITE;
			end else if (phase_q == PH_EOP) begin
				push         = 1'b1;
				push_op.kind = OP_REPLY;
				push_op.serr = cmd.rx_byte != B_EOP;
				unique case (cmd_q)
					CMD_GET_PARAM: begin
						push_op.rpl = RPL_DATA;
						priority if (psel_q == PARAM_MINOR)
							push_op.data = cfg.version_minor;
						else if (psel_q == PARAM_MAJOR)
							push_op.data = cfg.version_major;
						else
							push_op.data = PARAM_UNKNOWN;
					end
					CMD_UNIVERSAL: begin
						push_op.rpl  = RPL_DATA;
						push_op.data = UNIV_REPLY;
					end
					CMD_READ_PAGE: begin
						push_op.rpl = (plen_q != 16'd0) ? RPL_SYNC : RPL_SHORT;
					end
					CMD_READ_SIG: push_op.rpl = RPL_SIG;
					default: push_op.rpl = RPL_SHORT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= '0;
			bc_q    <= '0;
			addr_q  <= '0;
			plen_q  <= '0;
			psel_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			bc_q    <= bc_d;
			addr_q  <= addr_d;
			plen_q  <= plen_d;
			psel_q  <= psel_d;
			done_q  <= done_d;
		end
	end

endmodule

@@ hdl/stk_queue.sv @@
// Short operation queue between the parser and the executor.
`timescale 1ns / 1ps

module stk_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stk_pkg::op_t       push_op,
	input  logic               pop,
	output stk_pkg::op_t       pop_op,
	output stk_pkg::q_status_t q_st
);
	import stk_pkg::*;

	op_t             slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign q_st.full  = cnt_q == Q_CNT_FULL;
	assign q_st.empty = cnt_q == '0;
	assign pop_op     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hdl/stk_back.sv @@
// Executor: program store, reply sequencing and the output register.
`timescale 1ns / 1ps

module stk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  stk_pkg::cfg_t      cfg,
	input  stk_pkg::op_t       pop_op,
	input  stk_pkg::q_status_t q_st,
	output logic               pop,
	output logic               clr_busy,
	stk_rsp_if.source          rsp
);
	import stk_pkg::*;

	logic [7:0]          store_q [STORE_BYTES];
	logic                clr_q;
	logic [STORE_AW-1:0] clr_addr_q;
	logic [7:0]          rd_data_q;

	logic                cur_v_q;
	op_t                 cur_q;
	seq_idx_t            idx_q;
	seq_idx_t            cnt_m1;
	logic [7:0]          byte_sel;
	logic                last_byte;
	logic                emit;

	logic                out_v_q;
	logic [7:0]          tx_q;
	logic                last_q;
	logic                serr_q;
	logic                pend_q;
	logic                fin_q;

	assign clr_busy = clr_q;
	assign emit     = cur_v_q && (!out_v_q || rsp.ready);

	// reply length and byte at the current position
	always_comb begin
		cnt_m1   = 3'd0;
		byte_sel = B_OK;
		unique case (cur_q.kind)
			OP_READ: begin
				cnt_m1   = cur_q.last_rd ? 3'd1 : 3'd0;
				byte_sel = (idx_q == 3'd0) ? rd_data_q : B_OK;
			end
			OP_REPLY: begin
				unique case (cur_q.rpl)
					RPL_SYNC:  cnt_m1 = 3'd0;
					RPL_SHORT: cnt_m1 = 3'd1;
					RPL_DATA:  cnt_m1 = 3'd2;
					RPL_SIG:   cnt_m1 = 3'd4;
					default:   cnt_m1 = 3'd0;
				endcase
				if (idx_q == 3'd0)
					byte_sel = B_INSYNC;
				else if (cur_q.rpl == RPL_DATA && idx_q == 3'd1)
					byte_sel = cur_q.data;
				else if (cur_q.rpl == RPL_SIG) begin
					unique case (idx_q)
						3'd1:    byte_sel = cfg.signature_first;
						3'd2:    byte_sel = cfg.signature_second;
						3'd3:    byte_sel = cfg.signature_third;
						default: byte_sel = B_OK;
					endcase
				end
			end
			default: begin
				cnt_m1   = 3'd0;
				byte_sel = B_OK;
			end
		endcase
	end

	assign last_byte = idx_q == cnt_m1;
	assign pop = !clr_q && !q_st.empty && (!cur_v_q || (emit && last_byte));

	// store: clearing pass after reset, then writes from page programming
	always_ff @(posedge clk) begin
		if (clr_q)
			store_q[clr_addr_q] <= 8'h00;
		else if (pop && pop_op.kind == OP_WRITE)
			store_q[pop_op.addr] <= pop_op.data;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rd_data_q <= store_q[pop_op.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q)
				clr_q <= 1'b0;
		end
	end

	// current operation; writes finish on pop and never occupy it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			cur_q   <= '0;
			idx_q   <= '0;
		end else if (pop) begin
			cur_v_q <= pop_op.kind != OP_WRITE;
			cur_q   <= pop_op;
			idx_q   <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
			if (last_byte)
				cur_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			tx_q    <= '0;
			last_q  <= 1'b0;
			serr_q  <= 1'b0;
			pend_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
			tx_q    <= byte_sel;
			last_q  <= last_byte;
			serr_q  <= cur_q.serr;
			pend_q  <= cur_q.pending;
			fin_q   <= cur_q.finished;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.tx_byte      = tx_q;
	assign rsp.last         = last_q;
	assign rsp.sync_error   = serr_q;
	assign rsp.page_pending = pend_q;
	assign rsp.finished     = fin_q;

endmodule

@@ hdl/stk500_bootloader_engine_unit.sv @@
// Top level of the STK500 v1 bootloader responder engine.
//
//  channel  dir  handshake        carries
//  cmd      in   valid/ready      action, rx_byte
//  rsp      out  valid/ready      tx_byte, last, sync_error, page_pending, finished
//  cfg      in   cfg_we           cfg_index, cfg_data (8-bit registers)
//
// The parser takes one item per cycle while the operation queue has room and
// no clearing pass runs. Replies leave at one byte per cycle while rsp is ready;
// a page read byte follows its transmit slot through the queue, the registered
// store read and the output register. After reset a clearing pass zeroes all
// STORE_BYTES store bytes with cmd.ready low; configuration writes are taken
// throughout. A stalled rsp backs up into the queue and then holds cmd.ready low.
`timescale 1ns / 1ps
`include "stk500_bootloader_engine_unit_defines.svh"

module stk500_bootloader_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	stk_cmd_if.sink                        cmd,
	stk_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [stk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);
	import stk_pkg::*;

	cfg_t      cfg_q;
	q_status_t q_st;
	op_t       push_op;
	op_t       pop_op;
	logic      push;
	logic      pop;
	logic      clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_major    <= RST_VER_MAJOR;
			cfg_q.version_minor    <= RST_VER_MINOR;
			cfg_q.signature_first  <= RST_SIG_FIRST;
			cfg_q.signature_second <= RST_SIG_SECOND;
			cfg_q.signature_third  <= RST_SIG_THIRD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VER_MAJOR:  cfg_q.version_major    <= cfg_data;
				CFG_VER_MINOR:  cfg_q.version_minor    <= cfg_data;
				CFG_SIG_FIRST:  cfg_q.signature_first  <= cfg_data;
				CFG_SIG_SECOND: cfg_q.signature_second <= cfg_data;
				CFG_SIG_THIRD:  cfg_q.signature_third  <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	stk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.clr_busy (clr_busy),
		.q_st     (q_st),
		.push     (push),
		.push_op  (push_op)
	);

	stk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.q_st    (q_st)
	);

	stk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_op   (pop_op),
		.q_st     (q_st),
		.pop      (pop),
		.clr_busy (clr_busy),
		.rsp      (rsp)
	);

	`STK_ASSERT_IMP(a_no_transfer_in_clear, clk, arst_n, clr_busy, !(cmd.valid && cmd.ready), "input transfer during store clear")
	`STK_ASSERT_IMP(a_no_push_when_full, clk, arst_n, q_st.full, !push, "push into full queue")
	`STK_ASSERT_NXT(a_quiet_after_leave, clk, arst_n, push && push_op.finished, !push, "operation queued after leave programming")

endmodule
